@@ hw/rtl/pss_pkg.sv @@
// Package for the positional sequence store: sizes, operation and status
// codes, and the command that steers the row of storage cells.
// No dependencies.
package pss_pkg;

  localparam int CAPACITY   = 32;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int ELEM_W  = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e            mode;
    logic [IDX_W-1:0]      idx;
    logic [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

endpackage

@@ hw/rtl/pss_cell.sv @@
// One storage cell of the positional sequence store.
// Takes its next word from a neighbor, the insert value or the head cell.
// Depends on pss_pkg.
module pss_cell (
  input  logic                           clk_i,
  input  logic [pss_pkg::IDX_W-1:0]      cell_idx_i,
  input  pss_pkg::cell_cmd_t             cmd_i,
  input  logic [pss_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [pss_pkg::DATA_WIDTH-1:0] right_i,
  input  logic [pss_pkg::DATA_WIDTH-1:0] head_i,
  output logic [pss_pkg::DATA_WIDTH-1:0] data_o
);

  logic [pss_pkg::DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.mode)
      pss_pkg::CM_INSERT: begin
        if (cell_idx_i > cmd_i.idx) begin
          data_d = left_i;
        end else if (cell_idx_i == cmd_i.idx) begin
          data_d = cmd_i.value;
        end
      end
      pss_pkg::CM_DELETE: begin
        if (cell_idx_i >= cmd_i.idx) begin
          data_d = right_i;
        end
      end
      pss_pkg::CM_ROTATE: begin
        data_d = (cell_idx_i == cmd_i.idx) ? head_i : right_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/positional_sequence_store_core.sv @@
// Top level of the positional sequence store: request decode, occupancy,
// output register and the row of pss_cell storage cells.
// Depends on pss_pkg and pss_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: operation_i,
//   value_i, position_i. Output channel (out_valid_o/out_ready_i) carries
//   results: status_o, element_o, count_o, last_o.
//   Insert and delete requests shift the cell row at acceptance and give one
//   result in the cycle after acceptance; such requests can be accepted every
//   cycle while the output register is free or being drained.
//   A dump of N elements gives N results front to back, one per cycle while
//   the receiver takes them, from the head cell as the row rotates by one;
//   after N steps the row is back in order. No request is accepted until
//   the last dump result is loaded. An empty dump gives one result with
//   empty status. Reset clears the occupancy and out_valid_o; cell contents
//   and result fields are not cleared. A stalled receiver holds the current
//   result and blocks new requests and further dump steps until it is taken.
module positional_sequence_store_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pss_pkg::OP_W-1:0]    operation_i,
  input  logic [pss_pkg::VALUE_W-1:0] value_i,
  input  logic [pss_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pss_pkg::STAT_W-1:0]  status_o,
  output logic [pss_pkg::ELEM_W-1:0]  element_o,
  output logic [pss_pkg::COUNT_W-1:0] count_o,
  output logic                        last_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                              state_q, state_d;
  logic [pss_pkg::CNT_W-1:0]         cnt_q, cnt_d, cnt_m1;
  logic [pss_pkg::IDX_W-1:0]         dump_q, dump_d;
  logic                              out_valid_q;
  logic [pss_pkg::STAT_W-1:0]        status_q, status_d;
  logic [pss_pkg::ELEM_W-1:0]        element_q, element_d;
  logic [pss_pkg::COUNT_W-1:0]       count_q;
  logic                              last_q, last_d;
  logic                              load;
  logic                              out_free, accept, full;
  logic [pss_pkg::CMP_W-1:0]         pos_w, cnt_w;
  pss_pkg::cell_cmd_t                cmd;
  logic [pss_pkg::DATA_WIDTH-1:0]    cell_data [pss_pkg::CAPACITY];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == pss_pkg::CNT_W'(pss_pkg::CAPACITY));
  assign cnt_m1     = cnt_q - pss_pkg::CNT_W'(1);
  assign pos_w      = pss_pkg::CMP_W'(position_i);
  assign cnt_w      = pss_pkg::CMP_W'(cnt_q);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    dump_d    = dump_q;
    load      = 1'b0;
    status_d  = pss_pkg::STAT_OK;
    element_d = '0;
    last_d    = 1'b1;
    cmd.mode  = pss_pkg::CM_HOLD;
    cmd.idx   = '0;
    cmd.value = pss_pkg::DATA_WIDTH'(value_i);

    if (state_q == S_IDLE) begin
      if (accept) begin
        load = 1'b1;
        unique case (operation_i) inside
          pss_pkg::OP_INS_FRONT, pss_pkg::OP_INS_BACK: begin
            if (full) begin
              status_d = pss_pkg::STAT_FULL;
            end else begin
              cmd.mode = pss_pkg::CM_INSERT;
              cmd.idx  = (operation_i == pss_pkg::OP_INS_FRONT) ? '0
                         : pss_pkg::IDX_W'(cnt_q);
              cnt_d    = cnt_q + pss_pkg::CNT_W'(1);
            end
          end
          pss_pkg::OP_INS_POS: begin
            if (pos_w == '0 || pos_w > cnt_w + pss_pkg::CMP_W'(1)) begin
              status_d = pss_pkg::STAT_BADPOS;
            end else if (full) begin
              status_d = pss_pkg::STAT_FULL;
            end else begin
              cmd.mode = pss_pkg::CM_INSERT;
              cmd.idx  = pss_pkg::IDX_W'(pos_w - pss_pkg::CMP_W'(1));
              cnt_d    = cnt_q + pss_pkg::CNT_W'(1);
            end
          end
          pss_pkg::OP_DEL_FRONT, pss_pkg::OP_DEL_BACK: begin
            if (cnt_q == '0) begin
              status_d = pss_pkg::STAT_EMPTY;
            end else begin
              cmd.mode = pss_pkg::CM_DELETE;
              cmd.idx  = (operation_i == pss_pkg::OP_DEL_FRONT) ? '0
                         : pss_pkg::IDX_W'(cnt_m1);
              cnt_d    = cnt_m1;
            end
          end
          pss_pkg::OP_DEL_POS: begin
            if (pos_w == '0 || pos_w > cnt_w) begin
              status_d = pss_pkg::STAT_BADPOS;
            end else begin
              cmd.mode = pss_pkg::CM_DELETE;
              cmd.idx  = pss_pkg::IDX_W'(pos_w - pss_pkg::CMP_W'(1));
              cnt_d    = cnt_m1;
            end
          end
          pss_pkg::OP_DUMP: begin
            if (cnt_q == '0) begin
              status_d = pss_pkg::STAT_EMPTY;
            end else begin
              // first element now, the rest from the dump state
              element_d = pss_pkg::ELEM_W'(cell_data[0]);
              last_d    = (cnt_q == pss_pkg::CNT_W'(1));
              cmd.mode  = pss_pkg::CM_ROTATE;
              cmd.idx   = pss_pkg::IDX_W'(cnt_m1);
              dump_d    = pss_pkg::IDX_W'(1);
              if (cnt_q != pss_pkg::CNT_W'(1)) begin
                state_d = S_DUMP;
              end
            end
          end
          default: status_d = pss_pkg::STAT_BADPOS;
        endcase
      end
    end else begin
      if (out_free) begin
        load      = 1'b1;
        element_d = pss_pkg::ELEM_W'(cell_data[0]);
        last_d    = (dump_q == pss_pkg::IDX_W'(cnt_m1));
        cmd.mode  = pss_pkg::CM_ROTATE;
        cmd.idx   = pss_pkg::IDX_W'(cnt_m1);
        dump_d    = dump_q + pss_pkg::IDX_W'(1);
        if (last_d) begin
          state_d = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      dump_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dump_q  <= dump_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status_d;
      element_q <= element_d;
      count_q   <= pss_pkg::COUNT_W'(cnt_d);
      last_q    <= last_d;
    end
  end

  for (genvar g = 0; g < pss_pkg::CAPACITY; g++) begin : g_cell
    logic [pss_pkg::DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_data[g-1];
    end
    if (g == pss_pkg::CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[g+1];
    end
    pss_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (pss_pkg::IDX_W'(g)),
      .cmd_i      (cmd),
      .left_i     (left),
      .right_i    (right),
      .head_i     (cell_data[0]),
      .data_o     (cell_data[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign count_o     = count_q;
  assign last_o      = last_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pss_pkg::CNT_W'(pss_pkg::CAPACITY))
    else $error("occupancy above capacity");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) |=> $stable(cnt_q))
    else $error("occupancy changed without a request");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && load && last_d) |=> (state_q == S_IDLE))
    else $error("dump did not end after last element");

  a_no_req_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !accept)
    else $error("request accepted during dump");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for positional_sequence_store_core: a scoreboard class keeps a
// shadow copy of the ordered list and predicts every result; tasks drive random requests.
// Depends on pss_pkg and the core with its storage cells.
module testbench;
  import pss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int DRAIN_LIMIT = 400000;
  localparam int REPORT_CAP = 60;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ELEM_W-1:0]  element;
    logic [COUNT_W-1:0] count;
    logic               last;
  } pss_result_t;

  class pss_scoreboard;
    logic [DATA_WIDTH-1:0] shadow_list [CAPACITY];
    int unsigned           fill;
    pss_result_t           due_results [$];
    int unsigned           errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= REPORT_CAP)
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    function void due(logic [STAT_W-1:0] st, logic [ELEM_W-1:0] el, logic last);
      pss_result_t r;
      r.status = st;
      r.element = el;
      r.count = COUNT_W'(fill);
      r.last = last;
      due_results.push_back(r);
    endfunction

    function void place(int unsigned idx, logic [VALUE_W-1:0] value);
      int unsigned i;
      for (i = fill; i > idx; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[idx] = DATA_WIDTH'(value);
      fill++;
    endfunction

    function void remove(int unsigned idx);
      int unsigned i;
      for (i = idx; i + 1 < fill; i++) shadow_list[i] = shadow_list[i+1];
      fill--;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
      logic [STAT_W-1:0] st;
      int unsigned p;
      int unsigned i;
      st = STAT_OK;
      p = 32'(pos);
      case (op)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (fill >= CAPACITY) st = STAT_FULL;
          else place((op == OP_INS_FRONT) ? 0 : fill, value);
        end
        OP_INS_POS: begin
          if (p < 1 || p > fill + 1) st = STAT_BADPOS;
          else if (fill >= CAPACITY) st = STAT_FULL;
          else place(p - 1, value);
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (fill == 0) st = STAT_EMPTY;
          else remove((op == OP_DEL_FRONT) ? 0 : fill - 1);
        end
        OP_DEL_POS: begin
          if (p < 1 || p > fill) st = STAT_BADPOS;
          else remove(p - 1);
        end
        OP_DUMP: begin
          if (fill == 0) due(STAT_EMPTY, '0, 1'b1);
          for (i = 0; i < fill; i++)
            due(STAT_OK, ELEM_W'(shadow_list[i]), i + 1 == fill);
          return;
        end
        default: st = STAT_BADPOS;
      endcase
      due(st, '0, 1'b1);
    endfunction

    task check_result(logic [STAT_W-1:0] st, logic [ELEM_W-1:0] el,
                      logic [COUNT_W-1:0] cnt, logic last);
      pss_result_t want;
      if (due_results.size() == 0) begin
        report("result with nothing pending, element", el, 0);
      end else begin
        want = due_results.pop_front();
        if (st !== want.status) report("status", st, want.status);
        if (el !== want.element) report("element", el, want.element);
        if (cnt !== want.count) report("count", cnt, want.count);
        if (last !== want.last) report("last", last, want.last);
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [OP_W-1:0]     operation_i = '0;
  logic [VALUE_W-1:0]  value_i = '0;
  logic [POS_W-1:0]    position_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STAT_W-1:0]   status_o;
  logic [ELEM_W-1:0]   element_o;
  logic [COUNT_W-1:0]  count_o;
  logic                last_o;

  pss_scoreboard sb = new();

  positional_sequence_store_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // one request: optional idle gap, then hold valid until accepted
  task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [POS_W-1:0] pos, bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    value_i <= value;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, value, pos);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  task automatic send_random(int phase);
    int r;
    int ins_w;
    int del_w;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    case (phase)
      0, 2: begin ins_w = 84; del_w = 5; end
      1: begin ins_w = 5; del_w = 84; end
      default: begin ins_w = 40; del_w = 40; end
    endcase
    pos = POS_W'($urandom_range(0, 63));
    if (r < ins_w) begin
      op = OP_INS_FRONT + OP_W'($urandom_range(0, 2));
      if (op == OP_INS_POS && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(1, sb.fill + 1));
    end else if (r < ins_w + del_w) begin
      op = OP_DEL_FRONT + OP_W'($urandom_range(0, 2));
      if (op == OP_DEL_POS && sb.fill > 0 && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(1, sb.fill));
    end else if (r < ins_w + del_w + 6) begin
      op = OP_DUMP;
    end else begin
      op = OP_W'($urandom_range(0, 7));
    end
    send_request(op, pick_value(), pos, phase == 3);
  endtask

  // receiver: stall windows of random length between ready runs
  initial begin
    int gap;
    @(posedge clk_i iff rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12))
        @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, element_o, count_o, last_o);
  end

  initial begin
    int waited;
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_DUMP, '0, '0, 0);
    send_request(OP_DEL_FRONT, '0, '0, 0);
    send_request(OP_DEL_BACK, '0, '0, 0);
    send_request(OP_DEL_POS, '0, 6'd1, 0);
    send_request(OP_INS_POS, 32'h0bad_0001, 6'd0, 0);
    send_request(OP_INS_POS, 32'h0bad_0002, 6'd2, 0);
    send_request(OP_INS_POS, 32'h0000_0000, 6'd1, 0);
    send_request(OP_INS_FRONT, 32'hffff_ffff, '0, 0);
    send_request(OP_INS_BACK, 32'ha5a5_5a5a, '1, 0);
    send_request(OP_INS_POS, 32'h1234_5678, 6'd4, 0);
    send_request(OP_INS_POS, 32'h8000_0001, 6'd2, 0);
    send_request(OP_INS_POS, 32'h0bad_0003, 6'd63, 0);
    send_request(OP_DEL_POS, '0, 6'd0, 0);
    send_request(OP_DEL_POS, '0, 6'd6, 0);
    send_request(OP_DEL_POS, '0, 6'd63, 0);
    send_request(OP_UNUSED, '1, '1, 0);
    send_request(OP_DUMP, '1, '1, 0);
    send_request(OP_DEL_POS, '0, 6'd3, 0);
    send_request(OP_DEL_POS, '0, 6'd4, 0);
    send_request(OP_DEL_FRONT, '0, '0, 0);
    send_request(OP_DEL_BACK, '0, '0, 0);
    send_request(OP_DUMP, '0, '0, 0);
    send_request(OP_DEL_POS, '0, 6'd1, 0);
    send_request(OP_DUMP, '0, '0, 0);
    send_request(OP_INS_BACK, 32'h5555_aaaa, '0, 0);

    // grow to full, drain to empty, grow again, then a back-to-back mix
    for (n = 0; n < 180; n++) send_random((n / 45) % 4);
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.due_results.size() != 0)
      sb.report("results never delivered", sb.due_results.size(), 0);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/pss_pkg.sv
hw/rtl/pss_cell.sv
hw/rtl/positional_sequence_store_core.sv
tb/testbench.sv
